// ===== src/apc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package apc_pkg;

  localparam int SampleW      = 24;
  localparam int InShift      = 25 - SampleW;
  localparam int CfgW         = 32;
  localparam int CfgIdxW      = 3;
  localparam int LfoTableBits = 10;
  localparam int TableSize    = 1 << LfoTableBits;
  localparam int ShapeW       = 25;
  localparam int DivW         = 43;

  localparam int DefMaxStages = 24;
  localparam int DefLfoSkip   = 20;

  localparam logic [4:0]  RstNumStages = 5'd2;
  localparam logic [7:0]  RstDryWet    = 8'd128;
  localparam logic [31:0] RstLfoStep   = 32'd38956;
  localparam logic [15:0] RstStartPh   = 16'd0;
  localparam logic [7:0]  RstDepth     = 8'd100;
  localparam logic [7:0]  RstFeedback  = 8'd0;
  localparam logic [15:0] RstOutGain   = 16'd4096;

  localparam longint OneQ24  = 64'sd16777216;
  localparam longint OneQ30  = 64'sd1073741824;
  localparam longint TwoPiQ30 = 64'sd6746518852;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_STAGES = 3'd0,
    REG_DRY_WET    = 3'd1,
    REG_LFO_STEP   = 3'd2,
    REG_START_PH   = 3'd3,
    REG_DEPTH      = 3'd4,
    REG_FEEDBACK   = 3'd5,
    REG_OUT_GAIN   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DS_LFO,
    DS_FB,
    DS_OUT
  } div_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROM,
    ST_LMUL,
    ST_LDIV_GO,
    ST_LDIV_WAIT,
    ST_FDIV_GO,
    ST_FDIV_WAIT,
    ST_STAGE_A,
    ST_STAGE_B,
    ST_MIX_WET,
    ST_MIX_DRY,
    ST_MIX_GAIN,
    ST_ODIV_GO,
    ST_ODIV_WAIT,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    logic     rom_rd;
    logic     lmul;
    logic     div_go;
    div_src_e div_src;
    logic     gain_wr;
    logic     m_wr;
    logic     stage_a;
    logic     stage_b;
    logic     mix_wet;
    logic     mix_dry;
    logic     mix_gain;
    logic     out_wr;
  } apc_cmd_t;

  typedef struct packed {
    logic lfo_due;
    logic div_busy;
    logic stages_done;
  } apc_sts_t;

  typedef logic [ShapeW-1:0] shape_rom_t [TableSize];

  // long division of non-negative values, table build only
  function automatic longint udiv(input longint num, input longint den);
    longint q, r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  function automatic longint trig_series(input longint x, input bit odd);
    longint x2, term, sum, a;
    x2   = (x * x) >>> 30;
    term = odd ? x : OneQ30;
    sum  = 0;
    for (int i = 0; i < 14; i++) begin
      a    = odd ? longint'(2 * i + 2) : longint'(2 * i + 1);
      sum  = ((i & 1) == 1) ? sum - term : sum + term;
      term = udiv((term * x2) >>> 30, a * (a + 1));
    end
    if (sum < 0) sum = 0;
    if (sum > OneQ30) sum = OneQ30;
    return sum;
  endfunction

  function automatic longint cos_q30(input int k);
    int     quad, r;
    longint x, res;
    quad = (k >> (LfoTableBits - 2)) & 3;
    r    = k & ((TableSize >> 2) - 1);
    x    = (longint'(r) * TwoPiQ30) >>> LfoTableBits;
    if (quad == 0)      res = trig_series(x, 1'b0);
    else if (quad == 1) res = -trig_series(x, 1'b1);
    else if (quad == 2) res = -trig_series(x, 1'b0);
    else                res = trig_series(x, 1'b1);
    return res;
  endfunction

  function automatic longint expm1_q28(input longint u);
    longint sum, term, n;
    sum  = 0;
    term = u;
    n    = 1;
    while (term > 0 && n < 60) begin
      sum  = sum + term;
      n    = n + 1;
      term = udiv((term * u) >>> 28, n);
    end
    return sum;
  endfunction

  // shape of the sweep: expm1(2*(1+cos))/expm1(4), Q1.24
  function automatic shape_rom_t build_shape();
    shape_rom_t rom;
    longint     den, u, v;
    den = expm1_q28(longint'(4) <<< 28);
    for (int k = 0; k < TableSize; k++) begin
      u = (OneQ30 + cos_q30(k)) >>> 1;
      v = udiv(expm1_q28(u) * OneQ24 + (den >>> 1), den);
      if (v > OneQ24) v = OneQ24;
      rom[k] = ShapeW'(v);
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

// ===== src/apc_cdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apc_cdiv (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     by101_i,
  input  wire logic [apc_pkg::DivW-1:0] dividend_i,
  output logic                          busy_o,
  output logic [apc_pkg::DivW-1:0]      quot_o
);
  import apc_pkg::*;

  // reciprocal estimate from the top 32 bits (short by at most 277), a second
  // estimate on the remainder (short by at most one), then one compare
  localparam int LoW = DivW - 32;
  localparam int PW  = DivW + 8;
  localparam logic [28:0] RecipHi255 = 29'((longint'(1) <<< (LoW + 24)) / 255);
  localparam logic [28:0] RecipHi101 = 29'((longint'(1) <<< (LoW + 24)) / 101);
  localparam logic [17:0] RecipLo255 = 18'((longint'(1) <<< 24) / 255);
  localparam logic [17:0] RecipLo101 = 18'((longint'(1) <<< 24) / 101);

  logic [2:0]      cnt_q;
  logic [DivW-1:0] x_q;
  logic            by101_q;
  logic [DivW-1:0] qe_q;
  logic [16:0]     r_q;
  logic [10:0]     q2_q;
  logic [16:0]     r2_q;
  logic [DivW-1:0] qs_q;
  logic [7:0]      dsr;
  logic [28:0]     recip_hi;
  logic [17:0]     recip_lo;
  logic [60:0]     prod_hi;
  logic [PW-1:0]   qe_x_dsr;
  logic [DivW-1:0] r_full;
  logic [34:0]     prod_lo;
  logic [18:0]     q2_x_dsr;

  assign dsr      = by101_q ? 8'd101 : 8'd255;
  assign recip_hi = by101_q ? RecipHi101 : RecipHi255;
  assign recip_lo = by101_q ? RecipLo101 : RecipLo255;
  assign prod_hi  = 61'(x_q[DivW-1 -: 32]) * 61'(recip_hi);
  assign qe_x_dsr = PW'(qe_q) * PW'(dsr);
  assign r_full   = x_q - qe_x_dsr[DivW-1:0];
  assign prod_lo  = 35'(r_q) * 35'(recip_lo);
  assign q2_x_dsr = 19'(q2_q) * 19'(dsr);
  assign busy_o   = (cnt_q != '0);
  assign quot_o   = qs_q + DivW'(r2_q >= 17'(dsr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 3'd4;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q     <= dividend_i;
      by101_q <= by101_i;
    end
    if (cnt_q == 3'd4) begin
      qe_q <= DivW'(prod_hi[60:24]);
    end
    if (cnt_q == 3'd3) begin
      r_q <= r_full[16:0];
    end
    if (cnt_q == 3'd2) begin
      q2_q <= prod_lo[34:24];
    end
    if (cnt_q == 3'd1) begin
      r2_q <= r_q - q2_x_dsr[16:0];
      qs_q <= qe_q + DivW'(q2_q);
    end
  end

endmodule
`default_nettype wire

// ===== src/apc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apc_datapath #(
  parameter int MAX_STAGES = 24,
  parameter int LFO_SKIP   = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [apc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [apc_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic [apc_pkg::SampleW-1:0] sample_i,
  input  wire apc_pkg::apc_cmd_t           cmd_i,
  output apc_pkg::apc_sts_t                sts_o,
  output logic [apc_pkg::SampleW-1:0]      result_o
);
  import apc_pkg::*;

  localparam int NW   = $clog2(MAX_STAGES + 1);
  localparam int IW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int NSW  = (NW > 5) ? NW : 5;
  localparam int SKW  = (LFO_SKIP > 1) ? $clog2(LFO_SKIP) : 1;
  localparam int OutShift = 12 + InShift;
  localparam int OutBias  = (255 << OutShift) / 2;
  localparam logic [NSW-1:0] MaxEven = NSW'((MAX_STAGES / 2) * 2);
  localparam logic signed [43:0] YMax = 44'((1 <<< (SampleW - 1)) - 1);
  localparam logic signed [43:0] YMin = -44'(1 <<< (SampleW - 1));
  localparam shape_rom_t Shape = build_shape();

  function automatic logic signed [33:0] gmul(input logic [24:0] g,
                                              input logic signed [31:0] v);
    logic signed [57:0] p;
    p = $signed({1'b0, g}) * v;
    p = p + 58'sd8388608;
    return p[57:24];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
    logic signed [31:0] r;
    if (x > 44'sd2147483647)       r = 32'h7fff_ffff;
    else if (x < -44'sd2147483648) r = 32'h8000_0000;
    else                           r = x[31:0];
    return r;
  endfunction

  // configuration
  logic [4:0]         num_stages_q;
  logic [7:0]         dry_wet_q;
  logic [31:0]        lfo_step_q;
  logic [15:0]        start_ph_q;
  logic [7:0]         depth_q;
  logic signed [7:0]  feedback_q;
  logic [15:0]        out_gain_q;

  // state
  logic signed [31:0] mem_q [MAX_STAGES];
  logic signed [31:0] fb_q;
  logic [24:0]        gain_q;
  logic [SKW-1:0]     skip_q;
  logic [31:0]        angle_q;
  logic [NW-1:0]      siu_q;
  logic [NW-1:0]      j_q;

  // working registers
  logic signed [31:0] dry_q;
  logic signed [39:0] fbprod_q;
  logic [ShapeW-1:0]  rom_q;
  logic [31:0]        lprod_q;
  logic signed [31:0] m_q;
  logic signed [31:0] old_q;
  logic signed [31:0] nw_q;
  logic signed [40:0] wetp_q;
  logic signed [40:0] mixsum_q;
  logic signed [57:0] mixprod_q;
  logic [SampleW-1:0] y_q;

  logic [NSW-1:0]     ns_even;
  logic [NSW-1:0]     n_wide;
  logic [NW-1:0]      n_eff;
  logic [IW-1:0]      j_idx;
  logic signed [31:0] old_rd;
  logic signed [31:0] mul_v;
  logic signed [33:0] mul_res;
  logic signed [31:0] nw_d;
  logic [31:0]        angle_ph;
  logic [39:0]        fb_mag;
  logic [57:0]        mix_mag;
  logic [57:0]        out_num;
  logic [DivW-1:0]    dividend;
  logic               div_busy;
  logic [DivW-1:0]    quot;
  logic signed [43:0] q44;
  logic signed [43:0] fbq;
  logic signed [43:0] y44;

  assign ns_even = NSW'({num_stages_q[4:1], 1'b0});
  assign n_wide  = (ns_even > MaxEven) ? MaxEven : ns_even;
  assign n_eff   = n_wide[NW-1:0];
  assign j_idx   = j_q[IW-1:0];
  assign old_rd  = mem_q[j_idx];
  assign mul_v   = cmd_i.stage_b ? nw_q : old_rd;
  assign mul_res = gmul(gain_q, mul_v);
  assign nw_d    = sat32(44'(mul_res) + 44'(m_q));
  assign angle_ph = angle_q + {start_ph_q, 16'h0000};

  assign fb_mag  = fbprod_q[39] ? 40'(-fbprod_q) : 40'(fbprod_q);
  assign mix_mag = mixprod_q[57] ? 58'(-mixprod_q) : 58'(mixprod_q);
  assign out_num = (mix_mag + 58'(OutBias)) >> OutShift;

  always_comb begin
    unique case (cmd_i.div_src)
      DS_LFO:  dividend = DivW'(lprod_q);
      DS_FB:   dividend = DivW'(fb_mag);
      DS_OUT:  dividend = out_num[DivW-1:0];
      default: dividend = '0;
    endcase
  end

  apc_cdiv u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .by101_i    (cmd_i.div_src == DS_FB),
    .dividend_i (dividend),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign q44 = $signed({1'b0, quot});
  assign fbq = fbprod_q[39] ? -q44 : q44;
  assign y44 = mixprod_q[57] ? -q44 : q44;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_stages_q <= RstNumStages;
      dry_wet_q    <= RstDryWet;
      lfo_step_q   <= RstLfoStep;
      start_ph_q   <= RstStartPh;
      depth_q      <= RstDepth;
      feedback_q   <= RstFeedback;
      out_gain_q   <= RstOutGain;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_STAGES: num_stages_q <= cfg_data_i[4:0];
        REG_DRY_WET:    dry_wet_q    <= cfg_data_i[7:0];
        REG_LFO_STEP:   lfo_step_q   <= cfg_data_i[31:0];
        REG_START_PH:   start_ph_q   <= cfg_data_i[15:0];
        REG_DEPTH:      depth_q      <= cfg_data_i[7:0];
        REG_FEEDBACK:   feedback_q   <= cfg_data_i[7:0];
        REG_OUT_GAIN:   out_gain_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_STAGES; k++) begin
        mem_q[k] <= '0;
      end
    end else if (cmd_i.load) begin
      // stages that come into use start from zero
      for (int k = 0; k < MAX_STAGES; k++) begin
        if (NW'(k) >= siu_q && NW'(k) < n_eff) begin
          mem_q[k] <= '0;
        end
      end
    end else if (cmd_i.stage_a) begin
      mem_q[j_idx] <= nw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q    <= '0;
      gain_q  <= '0;
      skip_q  <= '0;
      angle_q <= '0;
      siu_q   <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        angle_q <= angle_q + lfo_step_q;
        skip_q  <= (skip_q == SKW'(LFO_SKIP - 1)) ? '0 : skip_q + 1'b1;
        siu_q   <= n_eff;
        j_q     <= '0;
      end
      if (cmd_i.gain_wr) begin
        gain_q <= 25'd16777216 - quot[24:0];
      end
      if (cmd_i.stage_b) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.mix_wet) begin
        fb_q <= m_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dry_q    <= 32'($signed(sample_i)) <<< InShift;
      fbprod_q <= 40'(fb_q) * 40'(feedback_q);
    end
    if (cmd_i.rom_rd) begin
      rom_q <= Shape[angle_ph[31 -: LfoTableBits]];
    end
    if (cmd_i.lmul) begin
      lprod_q <= 32'(rom_q) * 32'(depth_q) + 32'd127;
    end
    if (cmd_i.m_wr) begin
      m_q <= sat32(44'(dry_q) + fbq);
    end
    if (cmd_i.stage_a) begin
      old_q <= old_rd;
      nw_q  <= nw_d;
    end
    if (cmd_i.stage_b) begin
      m_q <= sat32(44'(old_q) - 44'(mul_res));
    end
    if (cmd_i.mix_wet) begin
      wetp_q <= 41'(m_q) * 41'($signed({1'b0, dry_wet_q}));
    end
    if (cmd_i.mix_dry) begin
      // 255 - dry_wet is the bitwise complement for 8 bits
      mixsum_q <= wetp_q + 41'(dry_q) * 41'($signed({1'b0, ~dry_wet_q}));
    end
    if (cmd_i.mix_gain) begin
      mixprod_q <= 58'(mixsum_q) * 58'($signed({1'b0, out_gain_q}));
    end
    if (cmd_i.out_wr) begin
      if (y44 > YMax)      y_q <= YMax[SampleW-1:0];
      else if (y44 < YMin) y_q <= YMin[SampleW-1:0];
      else                 y_q <= y44[SampleW-1:0];
    end
  end

  assign sts_o.lfo_due     = (skip_q == '0);
  assign sts_o.div_busy    = div_busy;
  assign sts_o.stages_done = (j_q == siu_q);
  assign result_o          = y_q;

endmodule
`default_nettype wire

// ===== src/apc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire apc_pkg::apc_sts_t sts_i,
  output apc_pkg::apc_cmd_t      cmd_o
);
  import apc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q;
  logic        slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = sts_i.lfo_due ? ST_ROM : ST_FDIV_GO;
      end
      ST_ROM:       state_d = ST_LMUL;
      ST_LMUL:      state_d = ST_LDIV_GO;
      ST_LDIV_GO:   state_d = ST_LDIV_WAIT;
      ST_LDIV_WAIT: if (!sts_i.div_busy) state_d = ST_FDIV_GO;
      ST_FDIV_GO:   state_d = ST_FDIV_WAIT;
      ST_FDIV_WAIT: if (!sts_i.div_busy) state_d = ST_STAGE_A;
      ST_STAGE_A:   state_d = sts_i.stages_done ? ST_MIX_WET : ST_STAGE_B;
      ST_STAGE_B:   state_d = ST_STAGE_A;
      ST_MIX_WET:   state_d = ST_MIX_DRY;
      ST_MIX_DRY:   state_d = ST_MIX_GAIN;
      ST_MIX_GAIN:  state_d = ST_ODIV_GO;
      ST_ODIV_GO:   state_d = ST_ODIV_WAIT;
      ST_ODIV_WAIT: if (!sts_i.div_busy) state_d = ST_OUT;
      ST_OUT:       if (slot_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_src = DS_LFO;
    unique case (state_q)
      ST_IDLE:      cmd_o.load = in_valid_i;
      ST_ROM:       cmd_o.rom_rd = 1'b1;
      ST_LMUL:      cmd_o.lmul = 1'b1;
      ST_LDIV_GO:   cmd_o.div_go = 1'b1;
      ST_LDIV_WAIT: cmd_o.gain_wr = !sts_i.div_busy;
      ST_FDIV_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = DS_FB;
      end
      ST_FDIV_WAIT: cmd_o.m_wr = !sts_i.div_busy;
      ST_STAGE_A:   cmd_o.stage_a = !sts_i.stages_done;
      ST_STAGE_B:   cmd_o.stage_b = 1'b1;
      ST_MIX_WET:   cmd_o.mix_wet = 1'b1;
      ST_MIX_DRY:   cmd_o.mix_dry = 1'b1;
      ST_MIX_GAIN:  cmd_o.mix_gain = 1'b1;
      ST_ODIV_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = DS_OUT;
      end
      ST_ODIV_WAIT: ;
      ST_OUT:       cmd_o.out_wr = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/allpass_phaser_with_lfo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Time per item grows with N, the stages in use, and is longer when the LFO
// gain is refreshed (one item in LFO_SKIP). It is set by the reciprocal constant
// divider (two or three divisions per item) and the stage step (STAGE_A, STAGE_B).
// Throughput: one item at a time; the next is taken in the cycle after the result is
// written, while it still waits; a result not yet taken holds the next one back.
// Reset: asynchronous, active low; clears stage memories and LFO, presets configuration.
module allpass_phaser_with_lfo #(
  parameter int MAX_STAGES = apc_pkg::DefMaxStages,
  parameter int LFO_SKIP   = apc_pkg::DefLfoSkip
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [apc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [apc_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [apc_pkg::SampleW-1:0] sample_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [apc_pkg::SampleW-1:0]      sample_out_o
);
  import apc_pkg::*;

  apc_cmd_t cmd;
  apc_sts_t sts;

  apc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  apc_datapath #(
    .MAX_STAGES (MAX_STAGES),
    .LFO_SKIP   (LFO_SKIP)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .result_o   (sample_out_o)
  );

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.div_busy)
    else $error("divider busy while waiting for an item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_wr |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before taken");

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid_i && in_ready_o))
    else $error("item loaded without handshake");

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_ready_o)
    else $error("ready again straight after an item");

endmodule
`default_nettype wire
